FILE: src/mvr_pkg.sv
// Shared types and constants for the motion vector reconstruction block.
// No dependencies; used by every module under src.
`default_nettype none

package mvr_pkg;

  localparam int unsigned NumFcodeRegs  = 4;
  localparam int unsigned NumPredictors = 8;
  localparam int unsigned QueueDepthDef = 2;

  localparam int unsigned FcodeW   = 4;
  localparam int unsigned MagW     = 5;
  localparam int unsigned ResidW   = 8;
  localparam int unsigned VecW     = 13;
  localparam int unsigned PredW    = 14;
  localparam int unsigned IdxW     = 3;
  localparam int unsigned RangeW   = 4;   // f_code minus one, 0..8

  localparam logic [MagW-1:0]   MaxMotionCode = MagW'(16);
  localparam logic [FcodeW-1:0] FcodeMin      = FcodeW'(1);
  localparam logic [FcodeW-1:0] FcodeMax      = FcodeW'(9);

  // register indexes on the configuration port
  localparam logic [1:0] RegFwdHor = 2'd0;
  localparam logic [1:0] RegFwdVer = 2'd1;
  localparam logic [1:0] RegBwdHor = 2'd2;
  localparam logic [1:0] RegBwdVer = 2'd3;

  typedef logic [FcodeW-1:0] fcode_t [NumFcodeRegs];

  // decoded item handed from front to back
  typedef struct packed {
    logic                    clear;
    logic                    halve;
    logic                    copy;
    logic [IdxW-1:0]         idx;
    logic [RangeW-1:0]       range;
    logic signed [PredW-1:0] delta;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

`default_nettype wire

FILE: src/mvr_front.sv
// Front end: unpacks an input word and forms index, range and differential.
// Depends on mvr_pkg.
`default_nettype none

module mvr_front (
  input  wire logic                       direction_i,
  input  wire logic                       vector_slot_i,
  input  wire logic                       component_i,
  input  wire logic [mvr_pkg::MagW-1:0]   motion_code_magnitude_i,
  input  wire logic                       code_sign_i,
  input  wire logic [mvr_pkg::ResidW-1:0] code_residual_i,
  input  wire logic                       halve_vertical_i,
  input  wire logic                       copy_to_second_i,
  input  wire logic                       clear_predictors_i,
  input  wire mvr_pkg::fcode_t            fcode_i,
  output mvr_pkg::cmd_t                   cmd_o
);

  logic [mvr_pkg::FcodeW-1:0] fc_raw;
  logic [mvr_pkg::FcodeW-1:0] fc_eff;
  logic [mvr_pkg::RangeW-1:0] range;
  logic [mvr_pkg::MagW-1:0]   mag_c;
  logic [mvr_pkg::ResidW-1:0] res_mask;
  logic [mvr_pkg::ResidW-1:0] res;
  logic [mvr_pkg::VecW-1:0]   base;
  logic [mvr_pkg::VecW-1:0]   mag_abs;

  always_comb begin
    fc_raw = fcode_i[{direction_i, component_i}];
    if (fc_raw < mvr_pkg::FcodeMin) begin
      fc_eff = mvr_pkg::FcodeMin;
    end else if (fc_raw > mvr_pkg::FcodeMax) begin
      fc_eff = mvr_pkg::FcodeMax;
    end else begin
      fc_eff = fc_raw;
    end
    range = fc_eff - mvr_pkg::FcodeMin;

    mag_c = (motion_code_magnitude_i > mvr_pkg::MaxMotionCode) ?
            mvr_pkg::MaxMotionCode : motion_code_magnitude_i;

    res_mask = mvr_pkg::ResidW'((9'd1 << range) - 9'd1);
    res      = code_residual_i & res_mask;
    base     = mvr_pkg::VecW'(mag_c - 5'd1) << range;
    mag_abs  = base + mvr_pkg::VecW'(res) + mvr_pkg::VecW'(1);

    cmd_o.clear = clear_predictors_i;
    cmd_o.halve = halve_vertical_i & component_i;
    cmd_o.copy  = copy_to_second_i;
    cmd_o.idx   = {direction_i, vector_slot_i, component_i};
    cmd_o.range = range;
    if (mag_c == '0) begin
      cmd_o.delta = '0;
    end else if (code_sign_i) begin
      cmd_o.delta = -$signed({1'b0, mag_abs});
    end else begin
      cmd_o.delta = $signed({1'b0, mag_abs});
    end
  end

endmodule

`default_nettype wire

FILE: src/mvr_queue.sv
// Short FIFO of decoded items between front end and back end.
// Depends on mvr_pkg for the item type.
`default_nettype none

module mvr_queue #(
  parameter int unsigned Depth = mvr_pkg::QueueDepthDef
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  wire mvr_pkg::cmd_t cmd_i,
  input  wire logic     pop_i,
  output mvr_pkg::cmd_t cmd_o,
  output mvr_pkg::qstat_t stat_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  mvr_pkg::cmd_t  mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  assign cmd_o        = mem_q[rd_ptr_q];
  assign stat_o.full  = (cnt_q == CntW'(Depth));
  assign stat_o.empty = (cnt_q == '0);

endmodule

`default_nettype wire

FILE: src/mvr_back.sv
// Back end: predictor store, add and wrap, result register.
// Depends on mvr_pkg.
`default_nettype none

module mvr_back (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire mvr_pkg::cmd_t                   cmd_i,
  input  wire mvr_pkg::qstat_t                 qstat_i,
  output logic                                 pop_o,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic signed [mvr_pkg::VecW-1:0]      vector_value_o,
  output logic signed [mvr_pkg::PredW-1:0]     predictor_value_o
);

  localparam int unsigned SumW = mvr_pkg::PredW + 1;
  localparam int unsigned ShW  = mvr_pkg::RangeW;

  logic signed [mvr_pkg::PredW-1:0] pred_q [mvr_pkg::NumPredictors];
  logic signed [mvr_pkg::PredW-1:0] pred_d [mvr_pkg::NumPredictors];
  logic                              out_valid_q;
  logic signed [mvr_pkg::VecW-1:0]  vec_q;
  logic signed [mvr_pkg::PredW-1:0] pv_q;

  logic signed [mvr_pkg::PredW-1:0] pred_rd;
  logic signed [mvr_pkg::PredW-1:0] pred_use;
  logic signed [SumW-1:0]           sum;
  logic signed [mvr_pkg::VecW-1:0]  sum_lo;
  logic signed [mvr_pkg::VecW-1:0]  sum_shl;
  logic [ShW-1:0]                   sh;
  logic signed [mvr_pkg::VecW-1:0]  vec;
  logic signed [mvr_pkg::PredW-1:0] stored;
  logic [mvr_pkg::IdxW-1:0]         copy_idx;

  assign pop_o = !qstat_i.empty && (!out_valid_q || out_ready_i);

  always_comb begin
    pred_rd  = pred_q[cmd_i.idx];
    pred_use = cmd_i.halve ? (pred_rd >>> 1) : pred_rd;
    sum      = SumW'(pred_use) + SumW'(cmd_i.delta);
    // keep the low 5+range bits and sign-extend from the top one
    sh       = ShW'(8) - cmd_i.range;
    sum_lo   = sum[mvr_pkg::VecW-1:0];
    sum_shl  = sum_lo <<< sh;
    vec      = sum_shl >>> sh;
    stored   = cmd_i.halve ? {vec, 1'b0} : mvr_pkg::PredW'(vec);
    copy_idx = {cmd_i.idx[2], 1'b1, cmd_i.idx[0]};

    pred_d = pred_q;
    if (cmd_i.clear) begin
      for (int i = 0; i < mvr_pkg::NumPredictors; i++) begin
        pred_d[i] = '0;
      end
    end else begin
      pred_d[cmd_i.idx] = stored;
      if (cmd_i.copy) begin
        pred_d[copy_idx] = stored;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < mvr_pkg::NumPredictors; i++) begin
        pred_q[i] <= '0;
      end
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        pred_q <= pred_d;
      end
      if (pop_o) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      vec_q <= cmd_i.clear ? '0 : vec;
      pv_q  <= cmd_i.clear ? '0 : stored;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign vector_value_o    = vec_q;
  assign predictor_value_o = pv_q;

endmodule

`default_nettype wire

FILE: src/motion_vector_reconstruct.sv
// Top level of the motion vector reconstruction block: f_code registers,
// front end, queue and back end. Depends on mvr_pkg, mvr_front, mvr_queue, mvr_back.
//
//  port group   dir   word layout (lsb first)
//  s_t*         in    tdata: direction, vector_slot, component, magnitude[5],
//                     sign, residual[8], halve_vertical, copy_to_second; tuser: clear
//  m_t*         out   tdata: vector_value[13], predictor_value[14]
//  p* (APB)     in    f_code registers at 0x0, 0x4, 0x8, 0xC
//
// One word per cycle sustained while m_t* does not stall. An accepted word enters
// the queue, is popped through the predictor read-modify-write into the result
// register, and can then leave on m_t*.
// Reset clears predictors and sets all f_codes to 1.
// Output stalls fill the queue, after which s_tready_o drops.
`default_nettype none

module motion_vector_reconstruct #(
  parameter int unsigned QueueDepth = mvr_pkg::QueueDepthDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_tvalid_i,
  output logic             s_tready_o,
  // [0] direction [1] vector_slot [2] component [7:3] motion_code_magnitude
  // [8] code_sign [16:9] code_residual [17] halve_vertical [18] copy_to_second
  input  wire logic [23:0] s_tdata_i,
  // [0] clear_predictors
  input  wire logic        s_tuser_i,
  output logic             m_tvalid_o,
  input  wire logic        m_tready_i,
  // [12:0] vector_value [26:13] predictor_value
  output logic [31:0]      m_tdata_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  mvr_pkg::fcode_t  fcode_q;
  mvr_pkg::cmd_t    front_cmd;
  mvr_pkg::cmd_t    q_cmd;
  mvr_pkg::qstat_t  q_stat;
  logic             push;
  logic             pop;
  logic             cfg_we;
  logic [1:0]       cfg_idx;
  logic signed [mvr_pkg::VecW-1:0]  vec_out;
  logic signed [mvr_pkg::PredW-1:0] pv_out;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[3:2];
  assign prdata  = 32'(fcode_q[cfg_idx]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fcode_q[mvr_pkg::RegFwdHor] <= mvr_pkg::FcodeMin;
      fcode_q[mvr_pkg::RegFwdVer] <= mvr_pkg::FcodeMin;
      fcode_q[mvr_pkg::RegBwdHor] <= mvr_pkg::FcodeMin;
      fcode_q[mvr_pkg::RegBwdVer] <= mvr_pkg::FcodeMin;
    end else if (cfg_we) begin
      fcode_q[cfg_idx] <= pwdata[mvr_pkg::FcodeW-1:0];
    end
  end

  assign s_tready_o = !q_stat.full;
  assign push       = s_tvalid_i && s_tready_o;

  mvr_front u_front (
    .direction_i             (s_tdata_i[0]),
    .vector_slot_i           (s_tdata_i[1]),
    .component_i             (s_tdata_i[2]),
    .motion_code_magnitude_i (s_tdata_i[7:3]),
    .code_sign_i             (s_tdata_i[8]),
    .code_residual_i         (s_tdata_i[16:9]),
    .halve_vertical_i        (s_tdata_i[17]),
    .copy_to_second_i        (s_tdata_i[18]),
    .clear_predictors_i      (s_tuser_i),
    .fcode_i                 (fcode_q),
    .cmd_o                   (front_cmd)
  );

  mvr_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (front_cmd),
    .pop_i  (pop),
    .cmd_o  (q_cmd),
    .stat_o (q_stat)
  );

  mvr_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (q_cmd),
    .qstat_i           (q_stat),
    .pop_o             (pop),
    .out_valid_o       (m_tvalid_o),
    .out_ready_i       (m_tready_i),
    .vector_value_o    (vec_out),
    .predictor_value_o (pv_out)
  );

  assign m_tdata_o = {5'd0, pv_out, vec_out};

`ifndef SYNTHESIS
  // never pop an empty queue
  a_no_empty_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_stat.empty |-> !pop)
    else $error("pop from empty queue");

  // a taken word with nothing behind it leaves the output empty
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && m_tready_i && !pop) |=> !m_tvalid_o)
    else $error("result word repeated");

  // stored predictor is the vector or twice the vector
  a_pred_vec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o |-> (pv_out == mvr_pkg::PredW'(vec_out)) || (pv_out == {vec_out, 1'b0}))
    else $error("predictor and vector disagree");
`endif

endmodule

`default_nettype wire
